// ===== src/fse_pkg.sv =====
// shared constants, register codes and cordic angle table for the fourier series evaluator
`default_nettype none

package fse_pkg;

  // default parameter values
  localparam int MAX_ORDER_DEF  = 3;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int COEF_BITS_DEF  = 16;

  // cordic setup
  localparam int CORDIC_ITERS = 16;
  localparam int ITER_W       = $clog2(CORDIC_ITERS);
  localparam int CW           = 32;
  localparam int TRIG_W       = 16;
  localparam logic signed [CW-1:0] CORDIC_X0 = 32'sd652032874;

  // result format
  localparam int OUT_W = 19;
  localparam int FRAC_SHIFT = 14;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_A1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_A2    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_B2    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_A3    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_B3    = 3'd7;

  // request types
  localparam logic REQ_SUM  = 1'b0;
  localparam logic REQ_TERM = 1'b1;

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic signed [CW-1:0] atan_lut(input logic [ITER_W-1:0] idx);
    logic signed [CW-1:0] v;
    case (idx)
      4'd0:    v = 32'sd536870912;
      4'd1:    v = 32'sd316933406;
      4'd2:    v = 32'sd167458907;
      4'd3:    v = 32'sd85004756;
      4'd4:    v = 32'sd42667331;
      4'd5:    v = 32'sd21354465;
      4'd6:    v = 32'sd10679838;
      4'd7:    v = 32'sd5340245;
      4'd8:    v = 32'sd2670163;
      4'd9:    v = 32'sd1335087;
      4'd10:   v = 32'sd667544;
      4'd11:   v = 32'sd333772;
      4'd12:   v = 32'sd166886;
      4'd13:   v = 32'sd83443;
      4'd14:   v = 32'sd41722;
      default: v = 32'sd20861;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== src/fourier_series_evaluator.sv =====
// truncated fourier series evaluator with one shared cordic and one shared multiplier
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  in      | to block  | in_valid / in_stall  | in_req_type, in_harmonic, in_angle
//  out     | from block| out_valid / out_stall| out_value
//  cfg     | to block  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one item at a time: each harmonic runs load, 16 cordic steps on the shared rotator, fold,
// two products and accumulate on the shared multiplier, then round and present; in_stall stays
// high from the input transfer until the output transfer and drops the cycle after it.
// synchronous active-low reset clears the sequencer and all configuration registers.
// cfg_ready is always high; the user must write the registers only while the block is idle,
// as the block itself does not enforce it.
`default_nettype none

module fourier_series_evaluator #(
  parameter int MAX_ORDER  = fse_pkg::MAX_ORDER_DEF,
  parameter int ANGLE_BITS = fse_pkg::ANGLE_BITS_DEF,
  parameter int COEF_BITS  = fse_pkg::COEF_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // input item
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire                                in_req_type,
  input  wire  [1:0]                         in_harmonic,
  input  wire  [ANGLE_BITS-1:0]              in_angle,
  // result item
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic signed [fse_pkg::OUT_W-1:0]   out_value,
  // configuration writes
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [fse_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [COEF_BITS-1:0]               cfg_data
);

  localparam int KW     = $clog2(MAX_ORDER + 1);
  localparam int PROD_W = COEF_BITS + fse_pkg::TRIG_W;
  localparam int ACC_W  = (COEF_BITS + 18 > 34) ? COEF_BITS + 18 : 34;
  localparam int RW     = ACC_W - fse_pkg::FRAC_SHIFT;
  localparam int CW     = fse_pkg::CW;
  localparam int OUT_W  = fse_pkg::OUT_W;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_CORDIC = 4'd2;
  localparam logic [3:0] S_FOLD   = 4'd3;
  localparam logic [3:0] S_MULC   = 4'd4;
  localparam logic [3:0] S_MULS   = 4'd5;
  localparam logic [3:0] S_ACCS   = 4'd6;
  localparam logic [3:0] S_ROUND  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state_r, state_nxt;

  // configuration registers
  logic [1:0]                  order_r;
  logic signed [COEF_BITS-1:0] coef_a0_r;
  logic signed [COEF_BITS-1:0] coef_a_r [1:MAX_ORDER];
  logic signed [COEF_BITS-1:0] coef_b_r [1:MAX_ORDER];

  // item registers
  logic [ANGLE_BITS-1:0]          angle_r;
  logic [ANGLE_BITS-1:0]          phase_r;
  logic [KW-1:0]                  k_r;
  logic [KW-1:0]                  last_k_r;
  logic signed [ACC_W-1:0]        acc_r;

  // cordic registers
  logic signed [CW-1:0]           x_r, y_r, z_r;
  logic [1:0]                     quad_r;
  logic [fse_pkg::ITER_W-1:0]     it_r;
  logic signed [fse_pkg::TRIG_W-1:0] cos_r, sin_r;

  // multiplier and output registers
  logic signed [PROD_W-1:0]       prod_r;
  logic                           out_valid_r;
  logic signed [OUT_W-1:0]        out_value_r;

  logic in_xfer, out_xfer, cfg_xfer;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_xfer  = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  // request decode at the input transfer
  logic [1:0]              ord_eff;
  logic signed [ACC_W-1:0] a0_scaled;
  logic                    no_harm;
  logic                    term_zero;

  assign ord_eff   = (order_r > 2'(MAX_ORDER)) ? 2'(MAX_ORDER) : order_r;
  assign a0_scaled = ACC_W'(coef_a0_r) <<< fse_pkg::FRAC_SHIFT;
  assign term_zero = (in_harmonic > 2'(MAX_ORDER));
  assign no_harm   = (in_req_type == fse_pkg::REQ_SUM) ? (ord_eff == 2'd0)
                                                       : (in_harmonic == 2'd0 || term_zero);

  // phase to cordic start value
  logic [CW-1:0]        phase_turn;
  logic signed [CW-1:0] z_init;

  assign phase_turn = CW'(phase_r) << (CW - ANGLE_BITS);
  assign z_init     = {2'b00, phase_turn[CW-3:0]};

  // one cordic micro-rotation
  logic signed [CW-1:0] dx, dy, atan_v;
  logic                 z_pos;

  assign dx     = y_r >>> it_r;
  assign dy     = x_r >>> it_r;
  assign atan_v = fse_pkg::atan_lut(it_r);
  assign z_pos  = !z_r[CW-1];

  // quadrant fold and rounding to q.14
  logic signed [CW-1:0] cx, cy, cx_rnd, cy_rnd;

  always_comb begin
    case (quad_r)
      2'd0:    begin cx = x_r;  cy = y_r;  end
      2'd1:    begin cx = -y_r; cy = x_r;  end
      2'd2:    begin cx = -x_r; cy = -y_r; end
      default: begin cx = y_r;  cy = -x_r; end
    endcase
  end

  assign cx_rnd = cx + 32'sd32768;
  assign cy_rnd = cy + 32'sd32768;

  // shared multiplier
  logic signed [COEF_BITS-1:0]       mul_a;
  logic signed [fse_pkg::TRIG_W-1:0] mul_b;

  assign mul_a = (state_r == S_MULC) ? coef_a_r[k_r] : coef_b_r[k_r];
  assign mul_b = (state_r == S_MULC) ? cos_r : sin_r;

  // rounding and saturation of the accumulator
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [RW-1:0]    res_wide;
  logic signed [OUT_W-1:0] res_sat;

  assign acc_rnd  = acc_r + ACC_W'(8192);
  assign res_wide = acc_rnd[ACC_W-1:fse_pkg::FRAC_SHIFT];

  always_comb begin
    if (res_wide[RW-1:OUT_W-1] == {(RW-OUT_W+1){res_wide[OUT_W-1]}}) begin
      res_sat = res_wide[OUT_W-1:0];
    end else if (res_wide[RW-1]) begin
      res_sat = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      res_sat = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = no_harm ? S_ROUND : S_START;
      end
      S_START:  state_nxt = S_CORDIC;
      S_CORDIC: begin
        if (it_r == fse_pkg::ITER_W'(fse_pkg::CORDIC_ITERS - 1)) state_nxt = S_FOLD;
      end
      S_FOLD:   state_nxt = S_MULC;
      S_MULC:   state_nxt = S_MULS;
      S_MULS:   state_nxt = S_ACCS;
      S_ACCS:   state_nxt = (k_r == last_k_r) ? S_ROUND : S_START;
      S_ROUND:  state_nxt = S_OUT;
      S_OUT: begin
        if (out_xfer) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_ROUND) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r   <= 2'd0;
      coef_a0_r <= '0;
      for (int j = 1; j <= MAX_ORDER; j++) begin
        coef_a_r[j] <= '0;
        coef_b_r[j] <= '0;
      end
    end else if (cfg_xfer) begin
      if (cfg_index == fse_pkg::CFG_ORDER) order_r <= cfg_data[1:0];
      if (cfg_index == fse_pkg::CFG_A0) coef_a0_r <= cfg_data;
      for (int j = 1; j <= MAX_ORDER; j++) begin
        if (cfg_index == fse_pkg::CFG_A1 + fse_pkg::CFG_IDX_W'(2 * (j - 1))) begin
          coef_a_r[j] <= cfg_data;
        end
        if (cfg_index == fse_pkg::CFG_B1 + fse_pkg::CFG_IDX_W'(2 * (j - 1))) begin
          coef_b_r[j] <= cfg_data;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          angle_r <= in_angle;
          if (in_req_type == fse_pkg::REQ_SUM) begin
            acc_r    <= a0_scaled;
            k_r      <= KW'(1);
            last_k_r <= KW'(ord_eff);
            phase_r  <= in_angle;
          end else begin
            acc_r    <= (in_harmonic == 2'd0) ? a0_scaled : '0;
            k_r      <= KW'(in_harmonic);
            last_k_r <= KW'(in_harmonic);
            phase_r  <= ANGLE_BITS'(in_angle * in_harmonic);
          end
        end
      end
      S_START: begin
        x_r    <= fse_pkg::CORDIC_X0;
        y_r    <= '0;
        z_r    <= z_init;
        quad_r <= phase_turn[CW-1:CW-2];
        it_r   <= '0;
      end
      S_CORDIC: begin
        if (z_pos) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - atan_v;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + atan_v;
        end
        it_r <= it_r + 1'b1;
      end
      S_FOLD: begin
        cos_r <= cx_rnd[CW-1:CW-fse_pkg::TRIG_W];
        sin_r <= cy_rnd[CW-1:CW-fse_pkg::TRIG_W];
      end
      S_MULC: begin
        prod_r <= mul_a * mul_b;
      end
      S_MULS: begin
        acc_r  <= acc_r + ACC_W'(prod_r);
        prod_r <= mul_a * mul_b;
      end
      S_ACCS: begin
        acc_r   <= acc_r + ACC_W'(prod_r);
        k_r     <= k_r + 1'b1;
        phase_r <= phase_r + angle_r;
      end
      S_ROUND: begin
        out_value_r <= res_sat;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  // a result is only shown in the output state
  a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_OUT))
    else $error("result valid outside output state");

  // no new item while a result is pending
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("input open while result pending");

  // the rotator runs exactly its fixed number of steps
  a_cordic_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CORDIC && it_r == fse_pkg::ITER_W'(fse_pkg::CORDIC_ITERS - 1))
    |=> (state_r == S_FOLD))
    else $error("cordic did not end after last step");

  // last harmonic leads to rounding
  a_last_harm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACCS && k_r == last_k_r) |=> (state_r == S_ROUND))
    else $error("sum did not stop at last harmonic");

  // result leaves only by a transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_stall) |=> (state_r == S_OUT && $stable(out_value_r)))
    else $error("result dropped while stalled");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the fourier series evaluator: cordic predictor, random traffic
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int DRAIN_CYCLES = 100;
  localparam longint VALUE_MAX = (64'sd1 <<< (fse_pkg::OUT_W - 1)) - 1;
  localparam longint VALUE_MIN = -(64'sd1 <<< (fse_pkg::OUT_W - 1));

  // atan(2^-i) in 2^32-per-turn units
  localparam longint ATAN_TURN [fse_pkg::CORDIC_ITERS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_req_type;
  logic [1:0] in_harmonic;
  logic [fse_pkg::ANGLE_BITS_DEF-1:0] in_angle;
  logic out_valid;
  logic out_stall;
  logic signed [fse_pkg::OUT_W-1:0] out_value;
  logic cfg_valid;
  logic cfg_ready;
  logic [fse_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fse_pkg::COEF_BITS_DEF-1:0] cfg_data;

  // register image kept alongside the block
  logic [1:0] model_order;
  logic signed [fse_pkg::COEF_BITS_DEF-1:0] model_a [4];
  logic signed [fse_pkg::COEF_BITS_DEF-1:0] model_b [4];

  logic signed [fse_pkg::OUT_W-1:0] pending_values [$];
  logic signed [fse_pkg::OUT_W-1:0] want_value;

  bit idle_on;
  int unsigned stall_left;
  int unsigned hold_off_left;
  int unsigned quiet_cycles;
  int fail_count;
  int items_sent;
  int sum_items;
  int term_items;
  int results_seen;
  int reg_writes;

  fourier_series_evaluator DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_harmonic (in_harmonic),
    .in_angle    (in_angle),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_value   (out_value),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // cos and sin of k*angle in Q.14 via 16-step rotation cordic
  function automatic void cordic_trig(input int unsigned k, input logic [15:0] ang,
                                      output longint c, output longint s);
    logic [31:0] turns;
    logic [31:0] ph;
    longint x, y, z, dx, dy, fx, fy;
    turns = ang * k;
    ph = {turns[15:0], 16'h0000};
    x = longint'(fse_pkg::CORDIC_X0);
    y = 0;
    z = longint'(ph[29:0]);
    for (int i = 0; i < fse_pkg::CORDIC_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURN[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TURN[i];
      end
    end
    // fold back from the first quadrant
    case (ph[31:30])
      2'd0: begin fx = x;  fy = y;  end
      2'd1: begin fx = -y; fy = x;  end
      2'd2: begin fx = -x; fy = -y; end
      default: begin fx = y; fy = -x; end
    endcase
    c = (fx + 32768) >>> 16;
    s = (fy + 32768) >>> 16;
  endfunction

  // one harmonic contribution in Q.14
  function automatic longint harmonic_term(input int unsigned k, input logic [15:0] ang);
    longint c, s;
    cordic_trig(k, ang, c, s);
    return longint'(model_a[k]) * c + longint'(model_b[k]) * s;
  endfunction

  // expected output for one request under the current register image
  function automatic logic signed [fse_pkg::OUT_W-1:0] series_value(input logic req,
                                                                    input logic [1:0] harm,
                                                                    input logic [15:0] ang);
    longint acc, r;
    if (req == fse_pkg::REQ_SUM) begin
      acc = longint'(model_a[0]) * 16384;
      for (int k = 1; k <= model_order && k <= fse_pkg::MAX_ORDER_DEF; k++)
        acc += harmonic_term(k, ang);
    end else if (harm == 2'd0) begin
      acc = longint'(model_a[0]) * 16384;
    end else if (int'(harm) > fse_pkg::MAX_ORDER_DEF) begin
      acc = 0;
    end else begin
      acc = harmonic_term(harm, ang);
    end
    r = (acc + 8192) >>> fse_pkg::FRAC_SHIFT;
    if (r > VALUE_MAX) r = VALUE_MAX;
    if (r < VALUE_MIN) r = VALUE_MIN;
    return r[fse_pkg::OUT_W-1:0];
  endfunction

  function automatic logic [15:0] pick_angle();
    logic [15:0] corners [6];
    corners = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'h5555};
    if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 5)];
    return 16'($urandom);
  endfunction

  // style 0 random, 1 full positive, 2 full negative, 3 large magnitude either sign
  function automatic logic [15:0] pick_coef(input int style);
    logic [15:0] v;
    case (style)
      1: v = 16'h7FFF;
      2: v = 16'h8000;
      3: v = $urandom_range(0, 1) ? 16'h7000 | 16'($urandom_range(0, 16'h0FFF))
                                  : 16'h8000 | 16'($urandom_range(0, 16'h0FFF));
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic report_fail(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%s", what);
  endtask

  // one register transfer, mirrored into the image
  task automatic write_reg(input logic [fse_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      fse_pkg::CFG_ORDER: model_order = data[1:0];
      fse_pkg::CFG_A0:    model_a[0] = data;
      fse_pkg::CFG_A1:    model_a[1] = data;
      fse_pkg::CFG_B1:    model_b[1] = data;
      fse_pkg::CFG_A2:    model_a[2] = data;
      fse_pkg::CFG_B2:    model_b[2] = data;
      fse_pkg::CFG_A3:    model_a[3] = data;
      default:            model_b[3] = data;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_regs(input logic [15:0] vals [8]);
    for (int i = fse_pkg::CFG_ORDER; i <= fse_pkg::CFG_B3; i++)
      write_reg(fse_pkg::CFG_IDX_W'(i), vals[i]);
  endtask

  // offer one request and hold it until the block takes it
  task automatic send_item(input logic req, input logic [1:0] harm, input logic [15:0] ang);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_req_type <= req;
    in_harmonic <= harm;
    in_angle <= ang;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_values = {pending_values, series_value(req, harm, ang)};
    items_sent++;
    if (req == fse_pkg::REQ_SUM) sum_items++;
    else term_items++;
  endtask

  task automatic send_random_item();
    send_item($urandom_range(0, 1) ? fse_pkg::REQ_TERM : fse_pkg::REQ_SUM,
              2'($urandom_range(0, 3)), pick_angle());
  endtask

  // quiet the input and let every outstanding result come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_reset_values();
    send_item(fse_pkg::REQ_SUM, 2'd3, 16'h1234);
    send_item(fse_pkg::REQ_TERM, 2'd2, 16'hEDCB);
    wait_idle();
  endtask

  task automatic test_full_scale();
    logic [15:0] vals [8];
    logic [15:0] angles [5];
    angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF};
    // order register with every unused bit set, all coefficients at full positive scale
    vals = '{16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
    load_regs(vals);
    foreach (angles[i]) send_item(fse_pkg::REQ_SUM, 2'd0, angles[i]);
    wait_idle();
    vals = '{16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
    load_regs(vals);
    send_item(fse_pkg::REQ_SUM, 2'd1, 16'h0000);
    send_item(fse_pkg::REQ_SUM, 2'd2, 16'h1555);
    send_item(fse_pkg::REQ_SUM, 2'd3, 16'hFFFF);
    wait_idle();
    // order zero leaves only the constant term
    write_reg(fse_pkg::CFG_ORDER, 16'hFFFC);
    send_item(fse_pkg::REQ_SUM, 2'd3, 16'h3000);
    wait_idle();
  endtask

  task automatic test_single_terms();
    logic [15:0] vals [8];
    vals = '{16'h0001, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
    load_regs(vals);
    // a single term ignores the configured order
    for (int h = 0; h < 4; h++) begin
      send_item(fse_pkg::REQ_TERM, 2'(h), 16'h2AAA);
      send_item(fse_pkg::REQ_TERM, 2'(h), 16'hD555);
    end
    wait_idle();
    write_reg(fse_pkg::CFG_ORDER, 16'h0002);
    send_item(fse_pkg::REQ_SUM, 2'd0, 16'h6000);
    wait_idle();
  endtask

  // receiver holds off while the sender keeps offering, so the input backs up
  task automatic test_output_backpressure();
    @(posedge clk);
    hold_off_left = HOLD_OFF_CYCLES;
    repeat (6) send_random_item();
    wait_idle();
  endtask

  task automatic run_phase(input int order, input int style, input int count);
    logic [15:0] vals [8];
    vals[fse_pkg::CFG_ORDER] = {16'($urandom) & 16'hFFFC} | 16'(order);
    for (int i = fse_pkg::CFG_A0; i <= fse_pkg::CFG_B3; i++) vals[i] = pick_coef(style);
    load_regs(vals);
    repeat (count) send_random_item();
    wait_idle();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 7; p++)
      run_phase((p * 3) % 4, (p < 4) ? p : $urandom_range(0, 3), 115);
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    run_phase(3, 0, 100);
    idle_on = 1'b1;
  endtask

  // receiver stall, counted per result
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_stall <= 1'b1;
      hold_off_left--;
    end else if (out_valid && stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result check on each output transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_values.size() == 0) begin
        report_fail($sformatf("unexpected result value=%0d", out_value));
      end else begin
        want_value = pending_values.pop_front();
        if (out_value !== want_value)
          report_fail($sformatf("value mismatch: expected %0d, got %0d",
                                want_value, out_value));
      end
      stall_left = idle_on ? $urandom_range(0, 10) : 0;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = fse_pkg::REQ_SUM;
    in_harmonic = '0;
    in_angle = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = fse_pkg::CFG_ORDER;
    cfg_data = '0;
    idle_on = 1'b1;
    stall_left = $urandom_range(0, 10);
    hold_off_left = 0;
    quiet_cycles = 0;
    fail_count = 0;
    items_sent = 0;
    sum_items = 0;
    term_items = 0;
    results_seen = 0;
    reg_writes = 0;
    model_order = '0;
    foreach (model_a[i]) begin
      model_a[i] = '0;
      model_b[i] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_full_scale();
    test_single_terms();
    test_output_backpressure();
    test_random_phases();
    test_back_to_back();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_values.size() != 0)
      report_fail($sformatf("%0d results never arrived", pending_values.size()));

    $display("run covered %0d requests (%0d series sums, %0d single terms), %0d register writes",
             items_sent, sum_items, term_items, reg_writes);
    $display("%0d results checked, %0d failures", results_seen, fail_count);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
